// ----- src/lru_set_associative_cache_model_top_assert.svh -----
// Assertion macros for the LRU cache tag store top level.
// Needs a clock named clk and a synchronous reset named rst in the including scope.
`ifndef LRU_SET_ASSOCIATIVE_CACHE_MODEL_TOP_ASSERT_SVH
`define LRU_SET_ASSOCIATIVE_CACHE_MODEL_TOP_ASSERT_SVH

// Checked at every clock edge outside reset.
`define LSAC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define LSAC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/lsac_pkg.sv -----
// Shared constants and types for the LRU set-associative cache tag store.
// No dependencies; imported by every module of the block.
package lsac_pkg;

  localparam int MAX_SET_BITS  = 8;
  localparam int MAX_WAYS      = 8;
  localparam int ADDRESS_BITS  = 48;
  localparam int MAX_OFF_BITS  = 32;

  localparam int SETS       = 1 << MAX_SET_BITS;
  localparam int SET_W      = MAX_SET_BITS;
  localparam int WAY_W      = $clog2(MAX_WAYS);
  localparam int RANK_W     = WAY_W;
  localparam int TAG_W      = ADDRESS_BITS - 2;  // offset and index take at least 2 bits
  localparam int CNT_W      = 32;
  localparam int SET_CFG_W  = 4;
  localparam int OFF_CFG_W  = 6;
  localparam int WAYS_CFG_W = 4;
  localparam int CFG_DATA_W = 6;
  localparam int CFG_IDX_W  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SET_BITS    = 2'd0,
    CFG_OFFSET_BITS = 2'd1,
    CFG_WAYS        = 2'd2
  } cfg_reg_t;

  // One set of the tag store, held as one memory row.
  typedef struct packed {
    logic [MAX_WAYS-1:0]             valid;
    logic [MAX_WAYS-1:0][TAG_W-1:0]  tag;
    logic [MAX_WAYS-1:0][RANK_W-1:0] rank;
  } row_t;

  // Running outcome of the way scan.
  typedef struct packed {
    logic              hit;
    logic [WAY_W-1:0]  hit_way;
    logic              free;
    logic [WAY_W-1:0]  free_way;
    logic [WAY_W-1:0]  victim_way;
    logic [RANK_W-1:0] best_rank;
  } scan_res_t;

endpackage

// ----- src/lru_set_associative_cache_model_top.sv -----
// LRU set-associative cache tag store. Each input transfer is one access (address, is_modify);
// each produces one result transfer with first_hit, evicted, second_hit and saturating
// hit/miss/eviction totals. After reset the block sweeps the 256-row tag memory, one row
// per cycle, and holds in_ready low meanwhile; config writes are taken at any time. Each
// accepted access then holds in_ready low while it runs in order: the address is split
// into set and tag, the set row is read, the shared compare unit then checks one way per
// cycle, and the row is written back with new ranks while the totals are updated. A
// modify's second lookup always hits and is folded into that write-back. The result sits
// in an output register, so the next access is accepted while a result still waits; the
// write-back stalls only if the previous result is untaken.
// Config registers take effect on the next access and are clamped to their legal range.
// Depends on lsac_pkg, lsac_row_ram, lsac_way_scan and the assertion macro header.
`include "lru_set_associative_cache_model_top_assert.svh"

module lru_set_associative_cache_model_top
  import lsac_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  // configuration writes
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  // access channel
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [ADDRESS_BITS-1:0] address,
  input  logic                    is_modify,
  // result channel
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    first_hit,
  output logic                    evicted,
  output logic                    second_hit,
  output logic [CNT_W-1:0]        hit_total,
  output logic [CNT_W-1:0]        miss_total,
  output logic [CNT_W-1:0]        eviction_total
);

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_DECODE = 6'b000100,
    S_READ   = 6'b001000,
    S_SCAN   = 6'b010000,
    S_UPDATE = 6'b100000
  } state_t;

  localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_WAYS - 1);

  state_t state;

  // config registers (raw values, clamped on use)
  logic [SET_CFG_W-1:0]  set_bits_reg;
  logic [OFF_CFG_W-1:0]  off_bits_reg;
  logic [WAYS_CFG_W-1:0] ways_reg;

  // per-access registers
  logic [ADDRESS_BITS-1:0] addr_q;
  logic                    modify_q;
  logic [SET_W-1:0]        set_q;
  logic [TAG_W-1:0]        tag_q;
  logic [WAY_W-1:0]        e_last_q;
  logic [WAY_W-1:0]        way_cnt;
  logic [SET_W-1:0]        clr_cnt;

  // clamped config and address split
  logic [SET_CFG_W-1:0]    s_cl;
  logic [OFF_CFG_W-1:0]    b_cl;
  logic [WAY_W-1:0]        e_last;
  logic [OFF_CFG_W-1:0]    sb;
  logic [SET_W:0]          mask_wide;
  logic [ADDRESS_BITS-1:0] shifted;
  logic [ADDRESS_BITS-1:0] tag_full;
  logic [SET_W-1:0]        set_next;
  logic [TAG_W-1:0]        tag_next;

  // memory and scan
  row_t      row_rd;
  row_t      row_new;
  scan_res_t res;
  logic      ram_wr_en;
  logic [SET_W-1:0] ram_wr_addr;
  row_t      ram_wr_data;
  logic      scan_clr;
  logic      scan_step;

  // write-back
  logic              upd_fire;
  logic [WAY_W-1:0]  slot;
  logic [RANK_W-1:0] hit_rank;
  logic              lane_other;

  // totals
  logic [1:0]       hit_inc;
  logic [CNT_W:0]   hit_sum;
  logic [CNT_W:0]   miss_sum;
  logic [CNT_W:0]   evict_sum;
  logic [CNT_W-1:0] hit_total_next;
  logic [CNT_W-1:0] miss_total_next;
  logic [CNT_W-1:0] eviction_total_next;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits_reg <= SET_CFG_W'(4);
      off_bits_reg <= OFF_CFG_W'(4);
      ways_reg     <= WAYS_CFG_W'(2);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SET_BITS:    set_bits_reg <= cfg_data[SET_CFG_W-1:0];
        CFG_OFFSET_BITS: off_bits_reg <= cfg_data[OFF_CFG_W-1:0];
        CFG_WAYS:        ways_reg     <= cfg_data[WAYS_CFG_W-1:0];
        default:         ;  // unknown index: ignored
      endcase
    end
  end

  // clamp config into its legal range
  always_comb begin
    if (set_bits_reg == '0) begin
      s_cl = SET_CFG_W'(1);
    end else if (set_bits_reg > SET_CFG_W'(MAX_SET_BITS)) begin
      s_cl = SET_CFG_W'(MAX_SET_BITS);
    end else begin
      s_cl = set_bits_reg;
    end
    if (off_bits_reg == '0) begin
      b_cl = OFF_CFG_W'(1);
    end else if (off_bits_reg > OFF_CFG_W'(MAX_OFF_BITS)) begin
      b_cl = OFF_CFG_W'(MAX_OFF_BITS);
    end else begin
      b_cl = off_bits_reg;
    end
    if (ways_reg == '0) begin
      e_last = '0;
    end else if (ways_reg > WAYS_CFG_W'(MAX_WAYS)) begin
      e_last = WAY_W'(MAX_WAYS - 1);
    end else begin
      e_last = WAY_W'(ways_reg - WAYS_CFG_W'(1));
    end
  end

  // address split: set above the offset, tag above the set
  always_comb begin
    sb        = OFF_CFG_W'(s_cl) + b_cl;
    mask_wide = (SET_W+1)'(1) << s_cl;
    mask_wide = mask_wide - (SET_W+1)'(1);
    shifted   = addr_q >> b_cl;
    tag_full  = addr_q >> sb;
    set_next  = shifted[SET_W-1:0] & mask_wide[SET_W-1:0];
    tag_next  = tag_full[TAG_W-1:0];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      way_cnt <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + SET_W'(1);
          if (clr_cnt == SET_W'(SETS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          state <= S_READ;
        end
        S_READ: begin
          way_cnt <= '0;
          state   <= S_SCAN;
        end
        S_SCAN: begin
          if (way_cnt == e_last_q) begin
            state <= S_UPDATE;
          end else begin
            way_cnt <= way_cnt + WAY_W'(1);
          end
        end
        S_UPDATE: begin
          if (upd_fire) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  // access payload capture
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      addr_q   <= address;
      modify_q <= is_modify;
    end
    if (state == S_DECODE) begin
      set_q    <= set_next;
      tag_q    <= tag_next;
      e_last_q <= e_last;
    end
  end

  assign scan_clr  = (state == S_READ);
  assign scan_step = (state == S_SCAN);

  lsac_row_ram u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (scan_clr),
    .rd_addr (set_q),
    .rd_data (row_rd)
  );

  lsac_way_scan u_scan (
    .clk  (clk),
    .clr  (scan_clr),
    .step (scan_step),
    .way  (way_cnt),
    .tag  (tag_q),
    .row  (row_rd),
    .res  (res)
  );

  // write-back waits only while an earlier result is still untaken
  assign upd_fire = (state == S_UPDATE) && (!out_valid || out_ready);

  // new row: each lane ages independently, then the touched way becomes MRU
  always_comb begin
    row_new  = row_rd;
    slot     = res.hit ? res.hit_way : (res.free ? res.free_way : res.victim_way);
    hit_rank = row_rd.rank[res.hit_way];
    for (int k = 0; k < MAX_WAYS; k++) begin
      lane_other = (WAY_W'(k) <= e_last_q) && (WAY_W'(k) != slot) && row_rd.valid[k];
      if (res.hit) begin
        if (lane_other && (row_rd.rank[k] < hit_rank)) begin
          row_new.rank[k] = row_rd.rank[k] + RANK_W'(1);
        end
      end else if (lane_other && (row_rd.rank[k] != RANK_MAX)) begin
        row_new.rank[k] = row_rd.rank[k] + RANK_W'(1);
      end
    end
    row_new.valid[slot] = 1'b1;
    row_new.tag[slot]   = tag_q;
    row_new.rank[slot]  = '0;
  end

  assign ram_wr_en   = (state == S_CLEAR) || upd_fire;
  assign ram_wr_addr = (state == S_CLEAR) ? clr_cnt : set_q;
  assign ram_wr_data = (state == S_CLEAR) ? row_t'('0) : row_new;

  // saturating totals; a modify's second lookup always counts as a hit
  always_comb begin
    hit_inc   = 2'(res.hit) + 2'(modify_q);
    hit_sum   = (CNT_W+1)'(hit_total) + (CNT_W+1)'(hit_inc);
    miss_sum  = (CNT_W+1)'(miss_total) + (CNT_W+1)'(!res.hit);
    evict_sum = (CNT_W+1)'(eviction_total) + (CNT_W+1)'(!res.hit && !res.free);
    hit_total_next      = hit_sum[CNT_W]   ? '1 : hit_sum[CNT_W-1:0];
    miss_total_next     = miss_sum[CNT_W]  ? '1 : miss_sum[CNT_W-1:0];
    eviction_total_next = evict_sum[CNT_W] ? '1 : evict_sum[CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      hit_total      <= '0;
      miss_total     <= '0;
      eviction_total <= '0;
    end else begin
      // a new result replaces one taken in the same cycle
      if (upd_fire) begin
        out_valid      <= 1'b1;
        hit_total      <= hit_total_next;
        miss_total     <= miss_total_next;
        eviction_total <= eviction_total_next;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd_fire) begin
      first_hit  <= res.hit;
      evicted    <= !res.hit && !res.free;
      second_hit <= modify_q;
    end
  end

  `LSAC_ASSERT(a_hits_no_decrease, 1'b1 |=> hit_total >= $past(hit_total), "hit total decreased")
  `LSAC_ASSERT(a_evict_only_on_miss, out_valid |-> !(evicted && first_hit), "eviction on a hit")
  `LSAC_ASSERT(a_accept_starts_decode, (in_valid && in_ready) |=> state == S_DECODE, "accept lost")
  `LSAC_ASSERT_ALWAYS(a_no_accept_in_clear, (state == S_CLEAR) |-> !in_ready, "accept in clear")

endmodule

// ----- src/lsac_row_ram.sv -----
// Tag store memory: one row per set, one write and one registered read port.
// Depends on lsac_pkg for row_t and the set count.
module lsac_row_ram
  import lsac_pkg::*;
(
  input  logic             clk,
  input  logic             wr_en,
  input  logic [SET_W-1:0] wr_addr,
  input  row_t             wr_data,
  input  logic             rd_en,
  input  logic [SET_W-1:0] rd_addr,
  output row_t             rd_data
);

  row_t mem [SETS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- src/lsac_way_scan.sv -----
// Shared tag/rank compare unit: examines one way of the fetched set per cycle.
// Depends on lsac_pkg for row_t and scan_res_t.
module lsac_way_scan
  import lsac_pkg::*;
(
  input  logic             clk,
  input  logic             clr,
  input  logic             step,
  input  logic [WAY_W-1:0] way,
  input  logic [TAG_W-1:0] tag,
  input  row_t             row,
  output scan_res_t        res
);

  logic              way_valid;
  logic [TAG_W-1:0]  way_tag;
  logic [RANK_W-1:0] way_rank;

  assign way_valid = row.valid[way];
  assign way_tag   = row.tag[way];
  assign way_rank  = row.rank[way];

  always_ff @(posedge clk) begin
    if (clr) begin
      res <= '0;
    end else if (step) begin
      // first matching valid way wins
      if (!res.hit && way_valid && (way_tag == tag)) begin
        res.hit     <= 1'b1;
        res.hit_way <= way;
      end
      if (!res.free && !way_valid) begin
        res.free     <= 1'b1;
        res.free_way <= way;
      end
      // oldest way, lowest index on ties
      if ((way == '0) || (way_rank > res.best_rank)) begin
        res.best_rank  <= way_rank;
        res.victim_way <= way;
      end
    end
  end

endmodule
